// ===== rtl/core/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion to Euler package
// Shared widths, CORDIC arctangent table and cell hand-off types.
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

   // datapath widths
   localparam int unsigned QUAT_W    = 16;
   localparam int unsigned ROLL_W    = 16;
   localparam int unsigned PITCH_W   = 15;
   localparam int unsigned YAW_W     = 17;
   localparam int unsigned VEC_W     = 34;   // CORDIC x/y
   localparam int unsigned ANG_W     = 34;   // Q30 angle, doubled fits
   localparam int unsigned TAB_LEN   = 24;
   localparam int unsigned SQ_W      = 58;   // radicand width
   localparam int unsigned SQRT_STEPS = 29;

   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [VEC_W-1:0] THRESH_Q28  = 34'sd133955584;

   // arctangent of 2^-i in Q30
   function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [ANG_W-1:0] r;
      unique case (idx)
         5'd0:  r = 34'sd843314857;
         5'd1:  r = 34'sd497837829;
         5'd2:  r = 34'sd263043836;
         5'd3:  r = 34'sd133525158;
         5'd4:  r = 34'sd67021686;
         5'd5:  r = 34'sd33543515;
         5'd6:  r = 34'sd16775850;
         5'd7:  r = 34'sd8388437;
         5'd8:  r = 34'sd4194282;
         5'd9:  r = 34'sd2097149;
         5'd10: r = 34'sd1048575;
         5'd11: r = 34'sd524287;
         5'd12: r = 34'sd262143;
         5'd13: r = 34'sd131071;
         5'd14: r = 34'sd65535;
         5'd15: r = 34'sd32767;
         5'd16: r = 34'sd16383;
         5'd17: r = 34'sd8191;
         5'd18: r = 34'sd4095;
         5'd19: r = 34'sd2047;
         5'd20: r = 34'sd1023;
         5'd21: r = 34'sd511;
         5'd22: r = 34'sd255;
         5'd23: r = 34'sd127;
         default: r = '0;
      endcase
      return r;
   endfunction

   // one CORDIC vector with its angle accumulator
   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
   } vec_type;

   // per-transaction side information that rides along the cell chain
   typedef struct packed {
      logic                    sing;   // gimbal lock
      logic                    tneg;   // t below zero
   } side_type;

endpackage

`default_nettype wire

// ===== rtl/core/q2e_stream_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Generic payload channel with source and sink views.
// ----------------------------------------------------------------------------
`default_nettype none

interface q2e_stream_if #(parameter int unsigned WIDTH = 64);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/quaternion_to_euler_zyx_unit.sv =====
// ----------------------------------------------------------------------------
// Quaternion to Z-Y-X Euler converter
// Path: product and sum registers, square root cells, pre-rotation register,
// CORDIC cells and output register, in that order; the cell chains set the depth.
// Throughput: one transaction per cycle; the whole chain advances when the
// output register is free or being drained.
// Reset: synchronous, clears the valid bits of every stage; no datapath reset.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_zyx_unit #(
   parameter int unsigned CORDIC_STAGES   = 16,
   parameter int unsigned ANGLE_FRAC_BITS = 13
) (
   input wire logic  clock,
   input wire logic  reset,
   q2e_stream_if.sink   req,
   q2e_stream_if.source rsp
);
   localparam int unsigned SQ   = q2e_pkg::SQRT_STEPS;
   localparam int unsigned NCS  = (CORDIC_STAGES < q2e_pkg::TAB_LEN) ?
                                  CORDIC_STAGES : q2e_pkg::TAB_LEN;
   // products, sums, square root, pre-rotation, CORDIC; output register follows
   localparam int unsigned DEPTH = 3 + SQ + NCS;
   localparam int unsigned SH    = 30 - ANGLE_FRAC_BITS;
   localparam logic signed [q2e_pkg::ANG_W-1:0] RND = q2e_pkg::ANG_W'(1) << (SH - 1);
   localparam longint unsigned PC_I =
      ((64'd15708 << ANGLE_FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam logic signed [q2e_pkg::PITCH_W-1:0] PITCH_C = q2e_pkg::PITCH_W'(PC_I);

   typedef logic signed [q2e_pkg::VEC_W-1:0] v_type;

   // full 32-bit product of two Q2.14 components
   function automatic v_type mul16(input logic signed [15:0] a,
                                   input logic signed [15:0] b);
      logic signed [31:0] p;
      p = a * b;
      return v_type'(p);
   endfunction

   logic advance;
   logic [DEPTH-1:0] vld_ff;
   logic out_vld_ff;
   logic [q2e_pkg::ROLL_W-1:0]  roll_ff;
   logic [q2e_pkg::PITCH_W-1:0] pitch_ff;
   logic [q2e_pkg::YAW_W-1:0]   yaw_ff;

   assign advance   = !out_vld_ff || rsp.ready;
   assign req.ready = advance;

   // stage 0: products
   logic signed [15:0] qx, qy, qz, qw;
   assign {qw, qz, qy, qx} = req.data;
   v_type wy_ff, xz_ff, yz_ff, wx_ff, xy_ff, wz_ff, ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [15:0] x1_ff, w1_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         wy_ff <= mul16(qw, qy); xz_ff <= mul16(qx, qz);
         yz_ff <= mul16(qy, qz); wx_ff <= mul16(qw, qx);
         xy_ff <= mul16(qx, qy); wz_ff <= mul16(qw, qz);
         ww_ff <= mul16(qw, qw); xx_ff <= mul16(qx, qx);
         yy_ff <= mul16(qy, qy); zz_ff <= mul16(qz, qz);
         x1_ff <= qx; w1_ff <= qw;
      end
   end

   // stage 1: sums, branch decision, s squared
   v_type t1, s_ff, ry_ff, rx_ff, yy2_ff, yx_ff, ay_ff, ax_ff;
   q2e_pkg::side_type side1_ff;
   logic [q2e_pkg::SQ_W-1:0] rad_ff;
   logic [q2e_pkg::VEC_W-1:0] mag;
   logic [59:0] mag_sq;
   assign t1  = wy_ff - xz_ff;
   assign mag = (t1 < 0) ? q2e_pkg::VEC_W'(-(t1 <<< 1)) : q2e_pkg::VEC_W'(t1 <<< 1);
   assign mag_sq = mag[29:0] * mag[29:0];
   always_ff @(posedge clock) begin
      if (advance) begin
         s_ff   <= t1 <<< 1;
         ry_ff  <= (yz_ff + wx_ff) <<< 1;
         rx_ff  <= ww_ff - xx_ff - yy_ff + zz_ff;
         yy2_ff <= (xy_ff + wz_ff) <<< 1;
         yx_ff  <= ww_ff + xx_ff - yy_ff - zz_ff;
         ay_ff  <= v_type'(x1_ff) <<< 14;
         ax_ff  <= v_type'(w1_ff) <<< 14;
         side1_ff.sing <= (t1 < -q2e_pkg::THRESH_Q28) || (t1 > q2e_pkg::THRESH_Q28);
         side1_ff.tneg <= t1 < 0;
         rad_ff <= (q2e_pkg::SQ_W'(1) << 56) - mag_sq[q2e_pkg::SQ_W-1:0];
      end
   end

   // square root chain; vectors ride along a delay line
   logic [q2e_pkg::SQ_W-1:0] rem [SQ+1];
   logic [q2e_pkg::SQ_W-1:0] root [SQ+1];
   assign rem[0]  = rad_ff;
   assign root[0] = '0;
   for (genvar g = 0; g < SQ; g++) begin : g_sqrt
      q2e_sqrt_cell #(.STEP(g)) u_cell (
         .clock(clock), .enable(advance),
         .rem_in_d(rem[g]), .root_in_d(root[g]),
         .rem_out(rem[g+1]), .root_out(root[g+1])
      );
   end

   typedef struct packed {
      v_type s, ry, rx, yy, yx, ay, ax;
      q2e_pkg::side_type side;
   } dly_type;
   dly_type dly_ff [SQ];
   always_ff @(posedge clock) begin
      if (advance) begin
         dly_ff[0] <= '{s_ff, ry_ff, rx_ff, yy2_ff, yx_ff, ay_ff, ax_ff, side1_ff};
         for (int k = 1; k < SQ; k++) dly_ff[k] <= dly_ff[k-1];
      end
   end

   // pre-rotation into the right half plane
   function automatic q2e_pkg::vec_type pre(input v_type yv, input v_type xv);
      q2e_pkg::vec_type r;
      r.x = xv; r.y = yv; r.z = '0;
      if (xv < 0) begin
         if (yv >= 0) begin
            r.x = yv; r.y = -xv; r.z = q2e_pkg::HALF_PI_Q30;
         end else begin
            r.x = -yv; r.y = xv; r.z = -q2e_pkg::HALF_PI_Q30;
         end
      end
      return r;
   endfunction

   // vector 0: roll or singular yaw, 1: pitch, 2: yaw; zero flags for atan2(0,0)
   dly_type d;
   assign d = dly_ff[SQ-1];
   q2e_pkg::vec_type vec [NCS+1][3];
   q2e_pkg::side_type side [NCS+1];
   q2e_pkg::vec_type pv_ff [3];
   q2e_pkg::side_type ps_ff;
   logic [2:0] zero_ff;
   logic [2:0] zero_d [NCS+1];
   always_ff @(posedge clock) begin
      if (advance) begin
         if (d.side.sing) begin
            pv_ff[0] <= pre(d.ay, d.ax);
            zero_ff[0] <= (d.ay == 0) && (d.ax == 0);
         end else begin
            pv_ff[0] <= pre(d.ry, d.rx);
            zero_ff[0] <= (d.ry == 0) && (d.rx == 0);
         end
         pv_ff[1] <= pre(d.s, v_type'(root[SQ]));
         zero_ff[1] <= (d.s == 0) && (root[SQ] == 0);
         pv_ff[2] <= pre(d.yy, d.yx);
         zero_ff[2] <= (d.yy == 0) && (d.yx == 0);
         ps_ff <= d.side;
      end
   end
   assign vec[0]    = pv_ff;
   assign side[0]   = ps_ff;
   assign zero_d[0] = zero_ff;

   for (genvar g = 0; g < NCS; g++) begin : g_cordic
      logic [2:0] zq_ff;
      q2e_cordic_cell #(.STAGE(g)) u_cell (
         .clock(clock), .enable(advance),
         .vec_d(vec[g]), .side_d(side[g]),
         .vec_q(vec[g+1]), .side_q(side[g+1])
      );
      always_ff @(posedge clock) begin
         if (advance) zq_ff <= zero_d[g];
      end
      assign zero_d[g+1] = zq_ff;
   end

   // rounding to output
   logic signed [q2e_pkg::ANG_W-1:0] a0, a1, a2, ya;
   q2e_pkg::side_type sf;
   assign sf = side[NCS];
   assign a0 = zero_d[NCS][0] ? '0 : vec[NCS][0].z;
   assign a1 = zero_d[NCS][1] ? '0 : vec[NCS][1].z;
   assign a2 = zero_d[NCS][2] ? '0 : vec[NCS][2].z;
   assign ya = sf.tneg ? (a0 <<< 1) : -(a0 <<< 1);
   logic signed [q2e_pkg::ANG_W-1:0] r0, r1, r2, ry;
   assign r0 = (a0 + RND) >>> SH;
   assign r1 = (a1 + RND) >>> SH;
   assign r2 = (a2 + RND) >>> SH;
   assign ry = (ya + RND) >>> SH;

   // valid chain and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff     <= {vld_ff[DEPTH-2:0], req.valid};
         out_vld_ff <= vld_ff[DEPTH-1];
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         if (sf.sing) begin
            roll_ff  <= '0;
            pitch_ff <= sf.tneg ? -PITCH_C : PITCH_C;
            yaw_ff   <= ry[q2e_pkg::YAW_W-1:0];
         end else begin
            roll_ff  <= r0[q2e_pkg::ROLL_W-1:0];
            pitch_ff <= r1[q2e_pkg::PITCH_W-1:0];
            yaw_ff   <= r2[q2e_pkg::YAW_W-1:0];
         end
      end
   end

   assign rsp.valid = out_vld_ff;
   assign rsp.data  = {yaw_ff, pitch_ff, roll_ff};

   // checks
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("response changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("input stalled with empty output");
   a_sing_roll: assert property (@(posedge clock) disable iff (reset)
      advance && sf.sing |=> roll_ff == '0)
      else $error("singular roll not zero");
endmodule

`default_nettype wire

// ===== rtl/core/q2e_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of a two-bit-per-cell integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_sqrt_cell #(
   parameter int unsigned STEP = 0
) (
   input  wire logic                                  clock,
   input  wire logic                                  enable,
   input  wire logic [q2e_pkg::SQ_W-1:0]              rem_in_d,
   input  wire logic [q2e_pkg::SQ_W-1:0]              root_in_d,
   output      logic [q2e_pkg::SQ_W-1:0]              rem_out,
   output      logic [q2e_pkg::SQ_W-1:0]              root_out
);
   localparam int unsigned BITPOS = 2 * (q2e_pkg::SQRT_STEPS - 1 - STEP);
   localparam logic [q2e_pkg::SQ_W-1:0] BIT = q2e_pkg::SQ_W'(1) << BITPOS;

   logic [q2e_pkg::SQ_W-1:0] rem_ff, root_ff, rem_in, root_in, trial;

   // compare and restore
   always_comb begin
      trial = root_in_d + BIT;
      if (rem_in_d >= trial) begin
         rem_in  = rem_in_d - trial;
         root_in = (root_in_d >> 1) + BIT;
      end else begin
         rem_in  = rem_in_d;
         root_in = root_in_d >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rem_out  = rem_ff;
   assign root_out = root_ff;
endmodule

`default_nettype wire

// ===== rtl/core/q2e_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC cell
// One vectoring micro-rotation for three vectors, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic_cell #(
   parameter int unsigned STAGE = 0
) (
   input  wire logic                clock,
   input  wire logic                enable,
   input  wire q2e_pkg::vec_type    vec_d [3],
   input  wire q2e_pkg::side_type   side_d,
   output      q2e_pkg::vec_type    vec_q [3],
   output      q2e_pkg::side_type   side_q
);
   localparam logic signed [q2e_pkg::ANG_W-1:0] ATAN = q2e_pkg::atan_q30(5'(STAGE));

   q2e_pkg::vec_type  vec_ff [3];
   q2e_pkg::vec_type  vec_in [3];
   q2e_pkg::side_type side_ff;

   // micro-rotation toward y = 0
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (vec_d[k].y > 0) begin
            vec_in[k].x = vec_d[k].x + (vec_d[k].y >>> STAGE);
            vec_in[k].y = vec_d[k].y - (vec_d[k].x >>> STAGE);
            vec_in[k].z = vec_d[k].z + ATAN;
         end else begin
            vec_in[k].x = vec_d[k].x - (vec_d[k].y >>> STAGE);
            vec_in[k].y = vec_d[k].y + (vec_d[k].x >>> STAGE);
            vec_in[k].z = vec_d[k].z - ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         vec_ff  <= vec_in;
         side_ff <= side_d;
      end
   end

   assign vec_q  = vec_ff;
   assign side_q = side_ff;
endmodule

`default_nettype wire
